FILE: sv/rtch_pkg.sv
// Package with shared types and constants of the ray/triangle closest-hit core.
package rtch_pkg;

  // Fixed-point formats and working widths.
  localparam int FRAC_BITS = 16;
  localparam int ID_BITS   = 16;
  localparam int UV_FRAC   = 16;
  localparam int WIDE_W    = 128;
  localparam int OP_W      = 33;
  localparam int P_W       = 52;
  localparam int Q_W       = 67;
  localparam int DIR_W     = 18;
  localparam int CRD_W     = 32;
  localparam int T_W       = 31;
  localparam int UV_W      = 17;
  localparam int TID_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Sequencing constants.
  localparam int MUL_STEPS = OP_W;
  localparam int DIV_STEPS = WIDE_W;
  localparam int N_STEPS   = 24;
  localparam int STEP_W    = $clog2(N_STEPS);
  localparam int TQ_DEPTH  = 2;

  // Epsilon of 0.00001 is handled as a divide by 100000.
  localparam int EPS_DIV = 100000;
  localparam logic [WIDE_W-1:0] DET_MIN =
      ((WIDE_W'(1) << (3 * FRAC_BITS)) + WIDE_W'(EPS_DIV - 1)) / WIDE_W'(EPS_DIV);
  localparam logic [T_W-1:0] T_NONE = '1;
  localparam logic [TID_W-1:0] ID_MASK = TID_W'((33'd1 << ID_BITS) - 33'd1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_idx_e;

  typedef logic signed [OP_W-1:0] coord_t;

  // One triangle after edge setup.
  typedef struct packed {
    coord_t [2:0]     e1;
    coord_t [2:0]     e2;
    coord_t [2:0]     tv;
    logic [TID_W-1:0] id;
    logic             last;
  } tri_t;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clr;
    logic sub;
  } mac_req_t;

  // One result.
  typedef struct packed {
    logic             hit;
    logic [T_W-1:0]   t;
    logic [UV_W-1:0]  u;
    logic [UV_W-1:0]  v;
    logic [TID_W-1:0] id;
  } res_t;

endpackage

FILE: sv/rtch_front.sv
// Front end: edge setup of each triangle and a short queue to the back end.
module rtch_front import rtch_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic signed [CRD_W-1:0] v0_x_i,
  input  logic signed [CRD_W-1:0] v0_y_i,
  input  logic signed [CRD_W-1:0] v0_z_i,
  input  logic signed [CRD_W-1:0] v1_x_i,
  input  logic signed [CRD_W-1:0] v1_y_i,
  input  logic signed [CRD_W-1:0] v1_z_i,
  input  logic signed [CRD_W-1:0] v2_x_i,
  input  logic signed [CRD_W-1:0] v2_y_i,
  input  logic signed [CRD_W-1:0] v2_z_i,
  input  logic [TID_W-1:0]        tri_id_i,
  input  logic                    last_tri_i,
  input  logic signed [CRD_W-1:0] org_x_i,
  input  logic signed [CRD_W-1:0] org_y_i,
  input  logic signed [CRD_W-1:0] org_z_i,
  output logic                    tri_valid_o,
  output tri_t                    tri_o,
  input  logic                    tri_pop_i
);

  localparam int AW = $clog2(TQ_DEPTH);
  localparam int CW = $clog2(TQ_DEPTH + 1);

  tri_t          new_tri;
  tri_t          mem_q [TQ_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          wr_en, rd_en;

  // Edges and origin offset, all exact in 33 bits.
  always_comb begin
    new_tri.e1[0] = OP_W'(v1_x_i) - OP_W'(v0_x_i);
    new_tri.e1[1] = OP_W'(v1_y_i) - OP_W'(v0_y_i);
    new_tri.e1[2] = OP_W'(v1_z_i) - OP_W'(v0_z_i);
    new_tri.e2[0] = OP_W'(v2_x_i) - OP_W'(v0_x_i);
    new_tri.e2[1] = OP_W'(v2_y_i) - OP_W'(v0_y_i);
    new_tri.e2[2] = OP_W'(v2_z_i) - OP_W'(v0_z_i);
    new_tri.tv[0] = OP_W'(org_x_i) - OP_W'(v0_x_i);
    new_tri.tv[1] = OP_W'(org_y_i) - OP_W'(v0_y_i);
    new_tri.tv[2] = OP_W'(org_z_i) - OP_W'(v0_z_i);
    new_tri.id    = tri_id_i;
    new_tri.last  = last_tri_i;
  end

  assign full        = (cnt_q == CW'(TQ_DEPTH));
  assign tri_valid_o = (cnt_q != '0);
  assign tri_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = tri_pop_i && tri_valid_o;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= new_tri;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: sv/rtch_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module rtch_mac import rtch_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_req_t                 req_i,
  input  logic signed [WIDE_W-1:0] a_i,
  input  logic signed [OP_W-1:0]   b_i,
  output logic                     busy_o,
  output logic signed [WIDE_W-1:0] acc_o
);

  localparam int MC_W = $clog2(MUL_STEPS);

  logic signed [WIDE_W-1:0] acc_q, a_q, term;
  logic [OP_W-1:0]          b_q;
  logic [MC_W-1:0]          cnt_q;
  logic                     busy_q, sub_q, neg;

  // The sign bit of the multiplier carries negative weight.
  always_comb begin
    neg  = (cnt_q == MC_W'(MUL_STEPS - 1)) ^ sub_q;
    term = '0;
    if (b_q[0]) begin
      term = neg ? -a_q : a_q;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      sub_q <= req_i.sub;
      if (req_i.clr) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q <= acc_q + term;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + MC_W'(1);
      if (cnt_q == MC_W'(MUL_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

FILE: sv/rtch_div.sv
// Radix-2 restoring divider for wide unsigned operands, one quotient bit per cycle.
module rtch_div import rtch_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WIDE_W-1:0] num_i,
  input  logic [WIDE_W-1:0] den_i,
  output logic              busy_o,
  output logic [WIDE_W-1:0] quo_o
);

  localparam int DC_W = $clog2(DIV_STEPS);

  logic [WIDE_W-1:0] num_q, den_q, rem_q, quo_q, rem_sh;
  logic [DC_W-1:0]   cnt_q;
  logic              busy_q, ge;

  // Bring down the next numerator bit and try to subtract.
  assign rem_sh = {rem_q[WIDE_W-2:0], num_q[WIDE_W-1]};
  assign ge     = (rem_sh >= den_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? (rem_sh - den_q) : rem_sh;
      quo_q <= {quo_q[WIDE_W-2:0], ge};
    end
  end

  // Bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DC_W'(1);
      if (cnt_q == DC_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/rtch_back.sv
// Back end: sequencer for the intersection test, closest-hit state and result register.
module rtch_back import rtch_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tri_valid_i,
  input  tri_t                    tri_i,
  output logic                    tri_pop_o,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic signed [DIR_W-1:0] dir_z_i,
  output logic                    res_valid_o,
  output res_t                    res_o,
  input  logic                    res_pop_i
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MUL   = 10'b0000000010,
    ST_NORM  = 10'b0000000100,
    ST_CHECK = 10'b0000001000,
    ST_TMUL  = 10'b0000010000,
    ST_TCHK  = 10'b0000100000,
    ST_TDIV  = 10'b0001000000,
    ST_UDIV  = 10'b0010000000,
    ST_VDIV  = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_e;

  state_e                   state_q;
  logic [STEP_W-1:0]        step_q;
  logic                     issued_q;
  tri_t                     tri_q;
  logic signed [P_W-1:0]    p_q [3];
  logic signed [Q_W-1:0]    q_q [3];
  logic signed [WIDE_W-1:0] det_q, unum_q, vnum_q, tnum_q;
  logic [T_W-1:0]           tq_q, best_t_q;
  logic [UV_W-1:0]          uq_q, best_u_q, best_v_q;
  logic [TID_W-1:0]         best_id_q;
  logic                     found_q;
  logic                     res_valid_q;
  res_t                     res_q;

  mac_req_t                 mac_req;
  logic signed [WIDE_W-1:0] mac_a, mac_acc, uv_sum;
  logic signed [OP_W-1:0]   mac_b;
  logic                     mac_busy;
  logic                     div_start, div_busy;
  logic [WIDE_W-1:0]        div_num, div_quo;
  logic                     mac_done, div_done, reject, t_better;
  coord_t                   dx, dy, dz;

  assign dx = OP_W'(dir_x_i);
  assign dy = OP_W'(dir_y_i);
  assign dz = OP_W'(dir_z_i);

  // Operand selection for each product of the cross and dot products.
  always_comb begin
    mac_a         = '0;
    mac_b         = '0;
    mac_req.start = ((state_q == ST_MUL) || (state_q == ST_TMUL)) && !issued_q;
    mac_req.clr   = step_q inside {5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd12, 5'd14, 5'd16,
                                   5'd18, 5'd21};
    mac_req.sub   = step_q inside {5'd1, 5'd3, 5'd5, 5'd13, 5'd15, 5'd17};
    case (step_q)
      5'd0:    begin mac_a = WIDE_W'(tri_q.e2[2]); mac_b = dy;          end
      5'd1:    begin mac_a = WIDE_W'(tri_q.e2[1]); mac_b = dz;          end
      5'd2:    begin mac_a = WIDE_W'(tri_q.e2[0]); mac_b = dz;          end
      5'd3:    begin mac_a = WIDE_W'(tri_q.e2[2]); mac_b = dx;          end
      5'd4:    begin mac_a = WIDE_W'(tri_q.e2[1]); mac_b = dx;          end
      5'd5:    begin mac_a = WIDE_W'(tri_q.e2[0]); mac_b = dy;          end
      5'd6:    begin mac_a = WIDE_W'(p_q[0]);      mac_b = tri_q.e1[0]; end
      5'd7:    begin mac_a = WIDE_W'(p_q[1]);      mac_b = tri_q.e1[1]; end
      5'd8:    begin mac_a = WIDE_W'(p_q[2]);      mac_b = tri_q.e1[2]; end
      5'd9:    begin mac_a = WIDE_W'(p_q[0]);      mac_b = tri_q.tv[0]; end
      5'd10:   begin mac_a = WIDE_W'(p_q[1]);      mac_b = tri_q.tv[1]; end
      5'd11:   begin mac_a = WIDE_W'(p_q[2]);      mac_b = tri_q.tv[2]; end
      5'd12:   begin mac_a = WIDE_W'(tri_q.tv[1]); mac_b = tri_q.e1[2]; end
      5'd13:   begin mac_a = WIDE_W'(tri_q.tv[2]); mac_b = tri_q.e1[1]; end
      5'd14:   begin mac_a = WIDE_W'(tri_q.tv[2]); mac_b = tri_q.e1[0]; end
      5'd15:   begin mac_a = WIDE_W'(tri_q.tv[0]); mac_b = tri_q.e1[2]; end
      5'd16:   begin mac_a = WIDE_W'(tri_q.tv[0]); mac_b = tri_q.e1[1]; end
      5'd17:   begin mac_a = WIDE_W'(tri_q.tv[1]); mac_b = tri_q.e1[0]; end
      5'd18:   begin mac_a = WIDE_W'(q_q[0]);      mac_b = dx;          end
      5'd19:   begin mac_a = WIDE_W'(q_q[1]);      mac_b = dy;          end
      5'd20:   begin mac_a = WIDE_W'(q_q[2]);      mac_b = dz;          end
      5'd21:   begin mac_a = WIDE_W'(q_q[0]);      mac_b = tri_q.e2[0]; end
      5'd22:   begin mac_a = WIDE_W'(q_q[1]);      mac_b = tri_q.e2[1]; end
      5'd23:   begin mac_a = WIDE_W'(q_q[2]);      mac_b = tri_q.e2[2]; end
      default: begin mac_a = '0;                   mac_b = '0;          end
    endcase
    // The distance epsilon test reuses the unit with a constant multiplier.
    if (state_q == ST_TMUL) begin
      mac_a       = tnum_q;
      mac_b       = $signed(OP_W'(EPS_DIV));
      mac_req.clr = 1'b1;
      mac_req.sub = 1'b0;
    end
  end

  // Divider operand selection.
  always_comb begin
    div_start = ((state_q == ST_TDIV) || (state_q == ST_UDIV) || (state_q == ST_VDIV))
                && !issued_q;
    case (state_q)
      ST_TDIV: div_num = $unsigned(tnum_q) << FRAC_BITS;
      ST_UDIV: div_num = $unsigned(unum_q) << UV_FRAC;
      default: div_num = $unsigned(vnum_q) << UV_FRAC;
    endcase
  end

  rtch_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  rtch_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ($unsigned(det_q)),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign mac_done  = issued_q && !mac_busy;
  assign div_done  = issued_q && !div_busy;
  assign tri_pop_o = (state_q == ST_IDLE) && tri_valid_i;

  // Bound tests on the sign-normalized numerators.
  assign uv_sum   = unum_q + vnum_q;
  assign reject   = (det_q < $signed(DET_MIN)) || unum_q[WIDE_W-1] || (unum_q > det_q) ||
                    vnum_q[WIDE_W-1] || (uv_sum > det_q);
  assign t_better = (div_quo < WIDE_W'(best_t_q));

  // Working registers of the current triangle.
  always_ff @(posedge clk_i) begin
    if (tri_pop_o) begin
      tri_q <= tri_i;
    end
    if ((state_q == ST_MUL) && mac_done) begin
      case (step_q)
        5'd1:    p_q[0] <= mac_acc[P_W-1:0];
        5'd3:    p_q[1] <= mac_acc[P_W-1:0];
        5'd5:    p_q[2] <= mac_acc[P_W-1:0];
        5'd8:    det_q  <= mac_acc;
        5'd11:   unum_q <= mac_acc;
        5'd13:   q_q[0] <= mac_acc[Q_W-1:0];
        5'd15:   q_q[1] <= mac_acc[Q_W-1:0];
        5'd17:   q_q[2] <= mac_acc[Q_W-1:0];
        5'd20:   vnum_q <= mac_acc;
        5'd23:   tnum_q <= mac_acc;
        default: ;
      endcase
    end
    if ((state_q == ST_NORM) && det_q[WIDE_W-1]) begin
      det_q  <= -det_q;
      unum_q <= -unum_q;
      vnum_q <= -vnum_q;
      tnum_q <= -tnum_q;
    end
    if ((state_q == ST_TDIV) && div_done) begin
      tq_q <= div_quo[T_W-1:0];
    end
    if ((state_q == ST_UDIV) && div_done) begin
      uq_q <= div_quo[UV_W-1:0];
    end
  end

  // Sequencer, closest-hit state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      issued_q    <= 1'b0;
      best_t_q    <= T_NONE;
      best_u_q    <= '0;
      best_v_q    <= '0;
      best_id_q   <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_valid_q && res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      if (mac_req.start || div_start) begin
        issued_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (tri_valid_i) begin
            step_q  <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            if (step_q == STEP_W'(N_STEPS - 1)) begin
              state_q <= ST_NORM;
            end else begin
              step_q <= step_q + STEP_W'(1);
            end
          end
        end
        ST_NORM: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (reject) begin
            state_q <= tri_q.last ? ST_EMIT : ST_IDLE;
          end else begin
            state_q <= ST_TMUL;
          end
        end
        ST_TMUL: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            state_q  <= ST_TCHK;
          end
        end
        ST_TCHK: begin
          if (mac_acc <= det_q) begin
            state_q <= tri_q.last ? ST_EMIT : ST_IDLE;
          end else begin
            state_q <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            issued_q <= 1'b0;
            if (t_better) begin
              state_q <= ST_UDIV;
            end else begin
              state_q <= tri_q.last ? ST_EMIT : ST_IDLE;
            end
          end
        end
        ST_UDIV: begin
          if (div_done) begin
            issued_q <= 1'b0;
            state_q  <= ST_VDIV;
          end
        end
        ST_VDIV: begin
          if (div_done) begin
            issued_q  <= 1'b0;
            best_t_q  <= tq_q;
            best_u_q  <= uq_q;
            best_v_q  <= div_quo[UV_W-1:0];
            best_id_q <= tri_q.id & ID_MASK;
            found_q   <= 1'b1;
            state_q   <= tri_q.last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!res_valid_q) begin
            res_valid_q <= 1'b1;
            res_q.hit   <= found_q;
            res_q.t     <= found_q ? best_t_q : '0;
            res_q.u     <= found_q ? best_u_q : '0;
            res_q.v     <= found_q ? best_v_q : '0;
            res_q.id    <= found_q ? best_id_q : '0;
            best_t_q    <= T_NONE;
            best_u_q    <= '0;
            best_v_q    <= '0;
            best_id_q   <= '0;
            found_q     <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: sv/ray_triangle_closest_hit_core.sv
// Top level of the ray/triangle closest-hit core.
//
// The ray is written through the configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i): origin x/y/z at indexes 0 to 2, direction x/y/z at 3 to 5.
// Writes to other indexes are dropped. cfg_ready_o is always high.
// Triangles enter as queue pushes: a request is taken when push is high and full is low.
// A run of triangles ends with the one that has last_tri_i set; that request makes one
// result, the closest hit of the run, and then the best-hit state starts over.
// Results leave as queue pops: the result is on the ports while empty is low and is
// taken when pop is high.
// A rejected triangle takes the 24 products of the bit-serial multiply-accumulate unit;
// one that passes the bound and distance tests also takes the radix-2 divider for t,
// and one that becomes the new closest hit takes it again for u and v. A two-entry
// queue lets the next triangles be pushed while one is being tested, and the result
// register lets work go on while a result waits.
// If the receiver stalls, a finished last triangle waits in the back end until the
// result register is free; pushes stop once the queue is full.
// Reset clears the ray registers, the queues and the best-hit state.
module ray_triangle_closest_hit_core import rtch_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CRD_W-1:0]        cfg_data_i,
  input  logic                    push,
  output logic                    full,
  input  logic signed [CRD_W-1:0] v0_x_i,
  input  logic signed [CRD_W-1:0] v0_y_i,
  input  logic signed [CRD_W-1:0] v0_z_i,
  input  logic signed [CRD_W-1:0] v1_x_i,
  input  logic signed [CRD_W-1:0] v1_y_i,
  input  logic signed [CRD_W-1:0] v1_z_i,
  input  logic signed [CRD_W-1:0] v2_x_i,
  input  logic signed [CRD_W-1:0] v2_y_i,
  input  logic signed [CRD_W-1:0] v2_z_i,
  input  logic [TID_W-1:0]        tri_id_i,
  input  logic                    last_tri_i,
  output logic                    empty,
  input  logic                    pop,
  output logic                    hit_o,
  output logic [T_W-1:0]          hit_t_o,
  output logic [UV_W-1:0]         hit_u_o,
  output logic [UV_W-1:0]         hit_v_o,
  output logic [TID_W-1:0]        hit_tri_id_o
);

  logic signed [CRD_W-1:0] org_x_q, org_y_q, org_z_q;
  logic signed [DIR_W-1:0] dir_x_q, dir_y_q, dir_z_q;
  logic                    tri_valid, tri_pop, res_valid;
  tri_t                    tri_entry;
  res_t                    res;

  assign cfg_ready_o = 1'b1;

  // Ray registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      dir_x_q <= '0;
      dir_y_q <= '0;
      dir_z_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ORG_X: org_x_q <= cfg_data_i;
        CFG_ORG_Y: org_y_q <= cfg_data_i;
        CFG_ORG_Z: org_z_q <= cfg_data_i;
        CFG_DIR_X: dir_x_q <= cfg_data_i[DIR_W-1:0];
        CFG_DIR_Y: dir_y_q <= cfg_data_i[DIR_W-1:0];
        CFG_DIR_Z: dir_z_q <= cfg_data_i[DIR_W-1:0];
        default:   ;
      endcase
    end
  end

  rtch_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .v0_x_i      (v0_x_i),
    .v0_y_i      (v0_y_i),
    .v0_z_i      (v0_z_i),
    .v1_x_i      (v1_x_i),
    .v1_y_i      (v1_y_i),
    .v1_z_i      (v1_z_i),
    .v2_x_i      (v2_x_i),
    .v2_y_i      (v2_y_i),
    .v2_z_i      (v2_z_i),
    .tri_id_i    (tri_id_i),
    .last_tri_i  (last_tri_i),
    .org_x_i     (org_x_q),
    .org_y_i     (org_y_q),
    .org_z_i     (org_z_q),
    .tri_valid_o (tri_valid),
    .tri_o       (tri_entry),
    .tri_pop_i   (tri_pop)
  );

  rtch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_valid_i (tri_valid),
    .tri_i       (tri_entry),
    .tri_pop_o   (tri_pop),
    .dir_x_i     (dir_x_q),
    .dir_y_i     (dir_y_q),
    .dir_z_i     (dir_z_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty        = !res_valid;
  assign hit_o        = res.hit;
  assign hit_t_o      = res.t;
  assign hit_u_o      = res.u;
  assign hit_v_o      = res.v;
  assign hit_tri_id_o = res.id;

endmodule

FILE: sv/rtch_checker.sv
// Port-level checker of the closest-hit core and its bind to the top level.
module rtch_checker import rtch_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic              hit_o,
  input logic [T_W-1:0]    hit_t_o,
  input logic [UV_W-1:0]   hit_u_o,
  input logic [UV_W-1:0]   hit_v_o,
  input logic [TID_W-1:0]  hit_tri_id_o
);

  // A miss reports all fields as zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !hit_o) |-> (hit_t_o == '0 && hit_u_o == '0 && hit_v_o == '0 &&
                            hit_tri_id_o == '0))
    else $error("miss result with nonzero fields");

  // Barycentrics of a hit stay inside the triangle.
  a_uv_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && hit_o) |-> ((18'(hit_u_o) + 18'(hit_v_o)) <= 18'd65536))
    else $error("hit barycentrics sum beyond one");

  // A hit distance is always below the no-hit marker.
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && hit_o) |-> (hit_t_o != T_NONE))
    else $error("hit with out-of-range distance");

  // A waiting result keeps its hit flag, distance and id until it is taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hit_o) && $stable(hit_t_o) &&
                          $stable(hit_tri_id_o)))
    else $error("result changed while waiting");

endmodule

bind ray_triangle_closest_hit_core rtch_checker u_rtch_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .hit_o        (hit_o),
  .hit_t_o      (hit_t_o),
  .hit_u_o      (hit_u_o),
  .hit_v_o      (hit_v_o),
  .hit_tri_id_o (hit_tri_id_o)
);
